FILE: sv/gcvc_pkg.sv
package gcvc_pkg;

    localparam int KEY_BITS_DEF = 16;

    localparam int OP_W     = 3;
    localparam int COORD_W  = 32;
    localparam int VERTEX_W = 48;
    localparam int ERR_W    = 2;
    localparam int RES_W    = 32;
    localparam int CNT_W    = 16;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // 2*pi in Q16.16 and the bits needed to hold it
    localparam logic [COORD_W-1:0] TWO_PI_Q16 = 32'd411775;
    localparam int YAW_DEN_W = 19;

    localparam int DIV_NUM_W_DEF = COORD_W;
    localparam int DIV_DEN_W_DEF = RES_W;
    localparam int DIV_LANES_DEF = 3;
    localparam int DIV_SB_W_DEF  = 1;

    localparam logic [RES_W-1:0] PLANE_RES_RST  = 32'd65536;
    localparam logic [RES_W-1:0] HEIGHT_RES_RST = 32'd65536;
    localparam logic [RES_W-1:0] POS_RES_RST    = 32'd0;
    localparam logic [RES_W-1:0] ANG_RES_RST    = 32'd0;
    localparam logic [CNT_W-1:0] ANG_CNT_RST    = 16'd0;

    typedef enum logic [OP_W-1:0] {
        OP_COORD_TO_VERTEX = 3'd0,
        OP_VERTEX_TO_COORD = 3'd1,
        OP_STATE_TO_VERTEX = 3'd2,
        OP_VERTEX_TO_STATE = 3'd3,
        OP_STATE_TO_ENV    = 3'd4
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_POS_RES   = 2'd1,
        ERR_ANG_RES   = 2'd2,
        ERR_KEY_RANGE = 2'd3
    } err_t;

    typedef enum logic [PADDR_W-3:0] {
        REG_PLANE_RES  = 3'd0,
        REG_HEIGHT_RES = 3'd1,
        REG_POS_RES    = 3'd2,
        REG_ANG_RES    = 3'd3,
        REG_ANG_COUNT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic                      three_dim;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [VERTEX_W-1:0]       vertex_in;
    } in_t;

    typedef struct packed {
        logic [VERTEX_W-1:0]       vertex_out;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [ERR_W-1:0]          error_code;
    } out_t;

endpackage

FILE: sv/gcvc_div.sv
module gcvc_div #(
    parameter int NUM_W = gcvc_pkg::DIV_NUM_W_DEF,
    parameter int DEN_W = gcvc_pkg::DIV_DEN_W_DEF,
    parameter int LANES = gcvc_pkg::DIV_LANES_DEF,
    parameter int SB_W  = gcvc_pkg::DIV_SB_W_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             in_vld,
    input  logic [NUM_W-1:0] in_num [LANES],
    input  logic [DEN_W-1:0] in_den [LANES],
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_vld,
    output logic [NUM_W-1:0] out_quo [LANES],
    output logic [DEN_W-1:0] out_rem [LANES],
    output logic [SB_W-1:0]  out_sb
);

    // restoring division, one quotient bit per stage
    logic [NUM_W-1:0] vld_reg, vld_next;
    logic [NUM_W-1:0] num_reg [NUM_W][LANES];
    logic [NUM_W-1:0] num_next [NUM_W][LANES];
    logic [NUM_W-1:0] num_src [NUM_W][LANES];
    logic [DEN_W-1:0] rem_reg [NUM_W][LANES];
    logic [DEN_W-1:0] rem_next [NUM_W][LANES];
    logic [DEN_W-1:0] rem_src [NUM_W][LANES];
    logic [DEN_W-1:0] den_reg [NUM_W][LANES];
    logic [DEN_W-1:0] den_src [NUM_W][LANES];
    logic [SB_W-1:0]  sb_reg [NUM_W];
    logic [SB_W-1:0]  sb_src [NUM_W];

    always_comb begin
        logic [DEN_W:0] trial;
        logic           take;
        vld_next = {vld_reg[NUM_W-2:0], in_vld};
        for (int l = 0; l < LANES; l++) begin
            num_src[0][l] = in_num[l];
            rem_src[0][l] = '0;
            den_src[0][l] = in_den[l];
        end
        sb_src[0] = in_sb;
        for (int s = 1; s < NUM_W; s++) begin
            num_src[s] = num_reg[s-1];
            rem_src[s] = rem_reg[s-1];
            den_src[s] = den_reg[s-1];
            sb_src[s]  = sb_reg[s-1];
        end
        for (int s = 0; s < NUM_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
                trial = {rem_src[s][l], num_src[s][l][NUM_W-1]};
                take  = trial >= {1'b0, den_src[s][l]};
                rem_next[s][l] = take ? DEN_W'(trial - {1'b0, den_src[s][l]})
                                      : trial[DEN_W-1:0];
                num_next[s][l] = {num_src[s][l][NUM_W-2:0], take};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (advance) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            den_reg <= den_src;
            sb_reg  <= sb_src;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_quo[l] = num_reg[NUM_W-1][l];
            out_rem[l] = rem_reg[NUM_W-1][l];
        end
    end

    assign out_vld = vld_reg[NUM_W-1];
    assign out_sb  = sb_reg[NUM_W-1];

endmodule

FILE: sv/grid_coordinate_vertex_converter_unit.sv
// channel | ports                         | dir | word
// input   | s_valid s_ready s_word        | in  | gcvc_pkg::in_t
// result  | m_valid m_ready m_word        | out | gcvc_pkg::out_t
// config  | psel penable pwrite paddr ... | in  | 32-bit registers at 4*index
//
// One word per cycle sustained while the pipe does not stall.
// The pipe is the input register, the 48-stage vertex/yaw-count divider, three centre
// stages, the 32-stage metric divider, the key stage and the output register.
// aresetn clears valids and loads the register reset values.
// The pipe stalls only when its last stage holds a word and the output register
// is full and not taken; s_ready follows that condition.
module grid_coordinate_vertex_converter_unit #(
    parameter int KEY_BITS = gcvc_pkg::KEY_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcvc_pkg::PADDR_W-1:0]  paddr,
    input  logic [gcvc_pkg::PDATA_W-1:0]  pwdata,
    output logic [gcvc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  gcvc_pkg::in_t                 s_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output gcvc_pkg::out_t                m_word
);

    import gcvc_pkg::*;

    localparam int WIDE_W     = (3 * KEY_BITS > VERTEX_W) ? 3 * KEY_BITS : VERTEX_W;
    localparam int OPND_W     = KEY_BITS + 2;
    localparam int PROD_W     = OPND_W + RES_W + 1;
    localparam int KEY_FULL_W = COORD_W + 3;
    localparam int PACK_W     = 2 * KEY_BITS + CNT_W + 1;
    localparam logic [OPND_W-1:0]     CTR_BIAS = OPND_W'(1) << KEY_BITS;
    localparam logic [KEY_FULL_W-1:0] KEY_OFF  = KEY_FULL_W'(1) << (KEY_BITS - 1);

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               three;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [VERTEX_W-1:0] vin;
    } ctx_a_t;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic                 three;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [COORD_W-1:0]   cz;
        logic [YAW_DEN_W-1:0] ra;
        logic [OPND_W-1:0]    ax;
        logic [OPND_W-1:0]    ay;
        logic [OPND_W-1:0]    az;
        logic                 z_half;
    } m1_t;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic                      three;
        logic [COORD_W-1:0]        cx;
        logic [COORD_W-1:0]        cy;
        logic [COORD_W-1:0]        cz;
        logic [YAW_DEN_W-1:0]      ra;
        logic signed [PROD_W-1:0]  px;
        logic signed [PROD_W-1:0]  py;
        logic signed [PROD_W-1:0]  pz;
        logic                      z_half;
    } m2_t;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic                 three;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [COORD_W-1:0]   cz;
        logic [YAW_DEN_W-1:0] ra;
        logic [COORD_W-1:0]   sx;
        logic [COORD_W-1:0]   sy;
        logic [COORD_W-1:0]   sz;
    } m3_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               three;
        logic [2:0]         neg;
        logic [2:0]         den_zero;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] sz;
    } ctx_b_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                three;
        logic [ERR_W-1:0]    err;
        logic [KEY_BITS-1:0] kx;
        logic [KEY_BITS-1:0] ky;
        logic [KEY_BITS-1:0] kz;
        logic [COORD_W-1:0]  sx;
        logic [COORD_W-1:0]  sy;
        logic [COORD_W-1:0]  sz;
    } p1_t;

    function automatic logic [COORD_W-1:0] mag(input logic [COORD_W-1:0] v);
        return v[COORD_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [OPND_W-1:0] ctr_opnd(input logic [KEY_BITS-1:0] k);
        return {1'b0, k, 1'b1} - CTR_BIAS;
    endfunction

    function automatic logic [COORD_W-1:0] sat(input logic [PROD_W-1:0] p);
        logic [PROD_W-COORD_W:0] hi;
        hi = p[PROD_W-1:COORD_W-1];
        if (&hi || !(|hi)) begin
            return p[COORD_W-1:0];
        end else if (p[PROD_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    // ---------------- configuration ----------------
    logic [RES_W-1:0] plane_res_reg, height_res_reg, pos_res_reg, ang_res_reg;
    logic [CNT_W-1:0] ang_cnt_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_res_reg  <= PLANE_RES_RST;
            height_res_reg <= HEIGHT_RES_RST;
            pos_res_reg    <= POS_RES_RST;
            ang_res_reg    <= ANG_RES_RST;
            ang_cnt_reg    <= ANG_CNT_RST;
        end else if (cfg_wr) begin
            case (cfg_reg_t'(paddr[PADDR_W-1:2]))
                REG_PLANE_RES:  plane_res_reg  <= pwdata[RES_W-1:0];
                REG_HEIGHT_RES: height_res_reg <= pwdata[RES_W-1:0];
                REG_POS_RES:    pos_res_reg    <= pwdata[RES_W-1:0];
                REG_ANG_RES:    ang_res_reg    <= pwdata[RES_W-1:0];
                REG_ANG_COUNT:  ang_cnt_reg    <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg_t'(paddr[PADDR_W-1:2]))
            REG_PLANE_RES:  prdata = PDATA_W'(plane_res_reg);
            REG_HEIGHT_RES: prdata = PDATA_W'(height_res_reg);
            REG_POS_RES:    prdata = PDATA_W'(pos_res_reg);
            REG_ANG_RES:    prdata = PDATA_W'(ang_res_reg);
            REG_ANG_COUNT:  prdata = PDATA_W'(ang_cnt_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic s0_vld_reg, m1_vld_reg, m2_vld_reg, m3_vld_reg, p1_vld_reg, m_valid_reg;
    logic diva_vld, divb_vld;
    in_t  s0_reg;
    m1_t  m1_reg, m1_next;
    m2_t  m2_reg, m2_next;
    m3_t  m3_reg, m3_next;
    p1_t  p1_reg, p1_next;
    out_t m_word_reg, out_next;

    assign adv     = !p1_vld_reg || !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg  <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_vld_reg  <= s_valid;
            m1_vld_reg  <= diva_vld;
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m2_vld_reg;
            p1_vld_reg  <= divb_vld;
            m_valid_reg <= p1_vld_reg || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_reg <= s_word;
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
            p1_reg <= p1_next;
        end
        if (adv && p1_vld_reg) begin
            m_word_reg <= out_next;
        end
    end

    // ---------------- vertex / yaw count divider ----------------
    logic [VERTEX_W-1:0]        diva_num [1];
    logic [YAW_DEN_W-1:0]       diva_den [1];
    logic [VERTEX_W-1:0]        diva_quo [1];
    logic [YAW_DEN_W-1:0]       diva_rem [1];
    logic [$bits(ctx_a_t)-1:0]  diva_sb_in, diva_sb_out;
    ctx_a_t                     ca;

    always_comb begin
        if (s0_reg.operation == OP_STATE_TO_VERTEX) begin
            diva_num[0] = VERTEX_W'(mag(s0_reg.coord_z));
            diva_den[0] = TWO_PI_Q16[YAW_DEN_W-1:0];
        end else begin
            diva_num[0] = s0_reg.vertex_in;
            diva_den[0] = YAW_DEN_W'(ang_cnt_reg);
        end
    end

    assign diva_sb_in = {s0_reg.operation, s0_reg.three_dim, s0_reg.coord_x,
                         s0_reg.coord_y, s0_reg.coord_z, s0_reg.vertex_in};

    gcvc_div #(
        .NUM_W(VERTEX_W),
        .DEN_W(YAW_DEN_W),
        .LANES(1),
        .SB_W ($bits(ctx_a_t))
    ) u_div_a (
        .aclk   (aclk),
        .aresetn(aresetn),
        .advance(adv),
        .in_vld (s0_vld_reg),
        .in_num (diva_num),
        .in_den (diva_den),
        .in_sb  (diva_sb_in),
        .out_vld(diva_vld),
        .out_quo(diva_quo),
        .out_rem(diva_rem),
        .out_sb (diva_sb_out)
    );

    assign ca = ctx_a_t'(diva_sb_out);

    // ---------------- cell centre stages ----------------
    always_comb begin
        logic [WIDE_W-1:0]   vin_w, q_w, r_w, dec_w;
        logic [KEY_BITS-1:0] kx, ky, kz;
        vin_w = WIDE_W'(ca.vin);
        q_w   = WIDE_W'(diva_quo[0]);
        r_w   = WIDE_W'(diva_rem[0]);
        dec_w = ca.three ? q_w : vin_w;
        m1_next.op    = ca.op;
        m1_next.three = ca.three;
        m1_next.cx    = ca.cx;
        m1_next.cy    = ca.cy;
        m1_next.cz    = ca.cz;
        m1_next.ra    = diva_rem[0];
        if (ca.op == OP_VERTEX_TO_COORD) begin
            kx = ca.three ? vin_w[3*KEY_BITS-1:2*KEY_BITS] : vin_w[2*KEY_BITS-1:KEY_BITS];
            ky = ca.three ? vin_w[2*KEY_BITS-1:KEY_BITS] : vin_w[KEY_BITS-1:0];
            kz = vin_w[KEY_BITS-1:0];
            m1_next.az     = ctr_opnd(kz);
            m1_next.z_half = 1'b1;
        end else begin
            kx = dec_w[2*KEY_BITS-1:KEY_BITS];
            ky = dec_w[KEY_BITS-1:0];
            kz = r_w[KEY_BITS-1:0];
            m1_next.az     = {2'b00, kz};
            m1_next.z_half = 1'b0;
        end
        m1_next.ax = ctr_opnd(kx);
        m1_next.ay = ctr_opnd(ky);
    end

    always_comb begin
        logic [RES_W-1:0] res_xy, res_z;
        res_xy = (m1_reg.op == OP_VERTEX_TO_COORD) ? plane_res_reg : pos_res_reg;
        res_z  = (m1_reg.op == OP_VERTEX_TO_COORD) ? height_res_reg : ang_res_reg;
        m2_next.op     = m1_reg.op;
        m2_next.three  = m1_reg.three;
        m2_next.cx     = m1_reg.cx;
        m2_next.cy     = m1_reg.cy;
        m2_next.cz     = m1_reg.cz;
        m2_next.ra     = m1_reg.ra;
        m2_next.z_half = m1_reg.z_half;
        m2_next.px = $signed(PROD_W'($signed(m1_reg.ax))) * $signed(PROD_W'({1'b0, res_xy}));
        m2_next.py = $signed(PROD_W'($signed(m1_reg.ay))) * $signed(PROD_W'({1'b0, res_xy}));
        m2_next.pz = $signed(PROD_W'($signed(m1_reg.az))) * $signed(PROD_W'({1'b0, res_z}));
    end

    always_comb begin
        m3_next.op    = m2_reg.op;
        m3_next.three = m2_reg.three;
        m3_next.cx    = m2_reg.cx;
        m3_next.cy    = m2_reg.cy;
        m3_next.cz    = m2_reg.cz;
        m3_next.ra    = m2_reg.ra;
        m3_next.sx    = sat(m2_reg.px >>> 1);
        m3_next.sy    = sat(m2_reg.py >>> 1);
        m3_next.sz    = m2_reg.z_half ? sat(m2_reg.pz >>> 1) : sat(m2_reg.pz);
    end

    // ---------------- metric divider ----------------
    logic [COORD_W-1:0]        divb_num [3];
    logic [RES_W-1:0]          divb_den [3];
    logic [COORD_W-1:0]        divb_quo [3];
    logic [RES_W-1:0]          divb_rem [3];
    logic [$bits(ctx_b_t)-1:0] divb_sb_out;
    ctx_b_t                    cb_in, cb;

    always_comb begin
        logic [COORD_W-1:0] nx, ny, nz, yn;
        logic [RES_W-1:0]   dxy, dz;
        yn = (m3_reg.cz[COORD_W-1] && (m3_reg.ra != '0))
           ? TWO_PI_Q16 - COORD_W'(m3_reg.ra) : COORD_W'(m3_reg.ra);
        nx  = (m3_reg.op == OP_STATE_TO_ENV) ? m3_reg.sx : m3_reg.cx;
        ny  = (m3_reg.op == OP_STATE_TO_ENV) ? m3_reg.sy : m3_reg.cy;
        dxy = (m3_reg.op == OP_STATE_TO_VERTEX) ? pos_res_reg : plane_res_reg;
        if (m3_reg.op == OP_STATE_TO_VERTEX) begin
            nz = yn;
            dz = ang_res_reg;
        end else begin
            nz = m3_reg.cz;
            dz = height_res_reg;
        end
        divb_num[0] = mag(nx);
        divb_num[1] = mag(ny);
        divb_num[2] = mag(nz);
        divb_den[0] = dxy;
        divb_den[1] = dxy;
        divb_den[2] = dz;
        cb_in.op       = m3_reg.op;
        cb_in.three    = m3_reg.three;
        cb_in.neg      = {nz[COORD_W-1], ny[COORD_W-1], nx[COORD_W-1]};
        cb_in.den_zero = {dz == '0, dxy == '0, dxy == '0};
        cb_in.sx       = m3_reg.sx;
        cb_in.sy       = m3_reg.sy;
        cb_in.sz       = m3_reg.sz;
    end

    gcvc_div #(
        .NUM_W(COORD_W),
        .DEN_W(RES_W),
        .LANES(3),
        .SB_W ($bits(ctx_b_t))
    ) u_div_b (
        .aclk   (aclk),
        .aresetn(aresetn),
        .advance(adv),
        .in_vld (m3_vld_reg),
        .in_num (divb_num),
        .in_den (divb_den),
        .in_sb  (cb_in),
        .out_vld(divb_vld),
        .out_quo(divb_quo),
        .out_rem(divb_rem),
        .out_sb (divb_sb_out)
    );

    assign cb = ctx_b_t'(divb_sb_out);

    // ---------------- keys and errors ----------------
    always_comb begin
        logic [KEY_FULL_W-1:0] qf, kf;
        logic [KEY_BITS-1:0]   key [3];
        logic [2:0]            rng;
        logic                  e_pos, e_ang, r_xy, r_z;
        for (int l = 0; l < 3; l++) begin
            qf = KEY_FULL_W'(divb_quo[l]);
            if (cb.den_zero[l]) begin
                qf = '0;
            end else if (cb.neg[l]) begin
                qf = -(qf + KEY_FULL_W'(divb_rem[l] != '0));
            end
            kf = (l == 2 && cb.op == OP_STATE_TO_VERTEX) ? qf : qf + KEY_OFF;
            rng[l] = |kf[KEY_FULL_W-1:KEY_BITS];
            key[l] = kf[KEY_BITS-1:0];
        end
        e_pos = pos_res_reg == '0;
        e_ang = cb.three && (ang_res_reg == '0 || ang_cnt_reg == '0);
        r_xy  = rng[0] || rng[1];
        r_z   = cb.three && rng[2];
        case (op_t'(cb.op))
            OP_COORD_TO_VERTEX: p1_next.err = (r_xy || r_z) ? ERR_KEY_RANGE : ERR_NONE;
            OP_STATE_TO_VERTEX: p1_next.err = e_pos ? ERR_POS_RES : e_ang ? ERR_ANG_RES
                                            : (r_xy || r_z) ? ERR_KEY_RANGE : ERR_NONE;
            OP_VERTEX_TO_STATE: p1_next.err = e_pos ? ERR_POS_RES : e_ang ? ERR_ANG_RES
                                            : ERR_NONE;
            OP_STATE_TO_ENV:    p1_next.err = e_pos ? ERR_POS_RES : e_ang ? ERR_ANG_RES
                                            : r_xy ? ERR_KEY_RANGE : ERR_NONE;
            default:            p1_next.err = ERR_NONE;
        endcase
        p1_next.op    = cb.op;
        p1_next.three = cb.three;
        p1_next.kx    = key[0];
        p1_next.ky    = key[1];
        p1_next.kz    = key[2];
        p1_next.sx    = cb.sx;
        p1_next.sy    = cb.sy;
        p1_next.sz    = cb.sz;
    end

    // ---------------- packing ----------------
    always_comb begin
        logic [PACK_W-1:0] pack;
        pack = PACK_W'({p1_reg.kx, p1_reg.ky}) * PACK_W'(ang_cnt_reg) + PACK_W'(p1_reg.kz);
        out_next = '0;
        out_next.error_code = p1_reg.err;
        if (p1_reg.err != ERR_POS_RES && p1_reg.err != ERR_ANG_RES) begin
            case (op_t'(p1_reg.op))
                OP_COORD_TO_VERTEX: begin
                    out_next.vertex_out = p1_reg.three
                        ? VERTEX_W'({p1_reg.kx, p1_reg.ky, p1_reg.kz})
                        : VERTEX_W'({p1_reg.kx, p1_reg.ky});
                end
                OP_STATE_TO_VERTEX: begin
                    out_next.vertex_out = p1_reg.three ? VERTEX_W'(pack)
                                                       : VERTEX_W'({p1_reg.kx, p1_reg.ky});
                end
                OP_STATE_TO_ENV: begin
                    out_next.vertex_out = VERTEX_W'({p1_reg.kx, p1_reg.ky});
                end
                OP_VERTEX_TO_COORD, OP_VERTEX_TO_STATE: begin
                    out_next.out_x = p1_reg.sx;
                    out_next.out_y = p1_reg.sy;
                    out_next.out_z = p1_reg.three ? p1_reg.sz : '0;
                end
                default: ;
            endcase
        end
    end

    // ---------------- checks ----------------
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word.error_code == ERR_POS_RES || m_word.error_code == ERR_ANG_RES)
        |-> m_word.vertex_out == '0 && m_word.out_x == '0 && m_word.out_y == '0
            && m_word.out_z == '0)
        else $error("setup error word carries data");

    a_enc_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.vertex_out != '0
        |-> m_word.out_x == '0 && m_word.out_y == '0 && m_word.out_z == '0)
        else $error("word carries both vertex and coordinates");

    a_tail_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_vld_reg && !s_ready |=> p1_vld_reg && $stable(p1_reg))
        else $error("stalled last stage lost its word");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gcvc_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 120;
    localparam longint KEY_OFF     = 32768;
    localparam longint KEY_CNT     = 65536;
    localparam longint TWO_PI      = 411775;

    typedef struct {
        in_t  word;
        bit   known;
        out_t result;
    } row_t;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    in_t                 s_word;
    logic                m_valid;
    logic                m_ready;
    out_t                m_word;

    grid_coordinate_vertex_converter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    logic [RES_W-1:0] plane_res, height_res, pos_res, ang_res;
    logic [CNT_W-1:0] ang_cnt;

    row_t  word_q[$];
    out_t  conv_expected_q[$];
    int    error_count;
    int    idle_cycles;
    bit    in_fire;
    bit    cur_known;
    out_t  cur_result;
    int    burst_left;
    int    gap_left;
    int    ready_cycle;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint floor_quot(longint n, longint d);
        if (d == 0) return 0;
        if (n >= 0) return n / d;
        return -((-n + d - 1) / d);
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint grid_key(longint q, ref logic [ERR_W-1:0] e);
        longint k;
        k = q + KEY_OFF;
        if ((k < 0 || k >= KEY_CNT) && e == ERR_NONE) e = ERR_KEY_RANGE;
        return k & (KEY_CNT - 1);
    endfunction

    function automatic longint cell_centre(longint k, longint res);
        longint p;
        p = (2 * (k - KEY_OFF) + 1) * res;
        return sat_s32(p >= 0 ? p / 2 : -((-p + 1) / 2));
    endfunction

    function automatic longint env_vertex(longint x, longint y, longint z, bit three,
                                          ref logic [ERR_W-1:0] e);
        longint v;
        v = grid_key(floor_quot(x, plane_res), e) * KEY_CNT
            + grid_key(floor_quot(y, plane_res), e);
        if (three) v = v * KEY_CNT + grid_key(floor_quot(z, height_res), e);
        return v & 64'hFFFF_FFFF_FFFF;
    endfunction

    function automatic void decode_state_vertex(longint unsigned v, bit three,
                                                ref longint x, ref longint y,
                                                ref longint yaw, ref logic [ERR_W-1:0] e);
        longint unsigned q;
        q = v;
        x = 0; y = 0; yaw = 0;
        if (pos_res == 0) begin
            if (e == ERR_NONE) e = ERR_POS_RES;
            return;
        end
        if (three) begin
            if (ang_res == 0 || ang_cnt == 0) begin
                if (e == ERR_NONE) e = ERR_ANG_RES;
                return;
            end
            q = v / ang_cnt;
            yaw = sat_s32(longint'(((v % ang_cnt) & (KEY_CNT - 1)) * longint'(ang_res)));
        end
        x = cell_centre(longint'((q >> 16) & (KEY_CNT - 1)), pos_res);
        y = cell_centre(longint'(q & (KEY_CNT - 1)), pos_res);
    endfunction

    function automatic out_t predict_conversion(in_t w);
        out_t r;
        logic [ERR_W-1:0] e;
        longint cx, cy, cz, ox, oy, oz, vout, yn, kyaw;
        longint unsigned vin;
        e = ERR_NONE;
        cx = longint'(w.coord_x);
        cy = longint'(w.coord_y);
        cz = longint'(w.coord_z);
        vin = w.vertex_in;
        vout = 0; ox = 0; oy = 0; oz = 0;
        case (w.operation)
            OP_COORD_TO_VERTEX: vout = env_vertex(cx, cy, cz, w.three_dim, e);
            OP_VERTEX_TO_COORD: begin
                if (w.three_dim) begin
                    ox = cell_centre(longint'((vin >> 32) & 16'hFFFF), plane_res);
                    oy = cell_centre(longint'((vin >> 16) & 16'hFFFF), plane_res);
                    oz = cell_centre(longint'(vin & 16'hFFFF), height_res);
                end else begin
                    ox = cell_centre(longint'((vin >> 16) & 16'hFFFF), plane_res);
                    oy = cell_centre(longint'(vin & 16'hFFFF), plane_res);
                end
            end
            OP_STATE_TO_VERTEX: begin
                if (pos_res == 0) begin
                    e = ERR_POS_RES;
                end else if (w.three_dim && (ang_res == 0 || ang_cnt == 0)) begin
                    e = ERR_ANG_RES;
                end else begin
                    vout = grid_key(floor_quot(cx, pos_res), e) * KEY_CNT
                           + grid_key(floor_quot(cy, pos_res), e);
                    if (w.three_dim) begin
                        yn = cz % TWO_PI;
                        if (yn < 0) yn += TWO_PI;
                        kyaw = floor_quot(yn, ang_res);
                        if (kyaw >= KEY_CNT && e == ERR_NONE) e = ERR_KEY_RANGE;
                        vout = vout * longint'(ang_cnt) + (kyaw & (KEY_CNT - 1));
                    end
                    vout &= 64'hFFFF_FFFF_FFFF;
                end
            end
            OP_VERTEX_TO_STATE: decode_state_vertex(vin, w.three_dim, ox, oy, oz, e);
            OP_STATE_TO_ENV: begin
                decode_state_vertex(vin, w.three_dim, ox, oy, oz, e);
                ox = 0; oy = 0; oz = 0;
                if (e == ERR_NONE) begin
                    decode_state_vertex(vin, w.three_dim, cx, cy, cz, e);
                    vout = env_vertex(cx, cy, 0, 1'b0, e);
                end
            end
            default: ;
        endcase
        r.vertex_out = vout[VERTEX_W-1:0];
        r.out_x = ox[31:0];
        r.out_y = oy[31:0];
        r.out_z = oz[31:0];
        r.error_code = e;
        return r;
    endfunction

    function automatic in_t make_word(logic [OP_W-1:0] op, bit three, logic [31:0] x,
                                      logic [31:0] y, logic [31:0] z, logic [47:0] v);
        in_t w;
        w.operation = op;
        w.three_dim = three;
        w.coord_x = x;
        w.coord_y = y;
        w.coord_z = z;
        w.vertex_in = v;
        return w;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 4000000) - 2000000;
            2: return $urandom_range(0, 200) - 100;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [47:0] rand_vertex();
        longint kx, ky, yaw, v;
        kx = KEY_OFF + $urandom_range(0, 64) - 32;
        ky = KEY_OFF + $urandom_range(0, 64) - 32;
        case ($urandom_range(0, 2))
            0: v = {$urandom, $urandom};
            1: v = (kx * KEY_CNT + ky) * KEY_CNT + $urandom_range(0, 65535);
            default: begin
                yaw = (ang_cnt == 0) ? 0 : $urandom_range(0, ang_cnt - 1);
                v = (kx * KEY_CNT + ky) * longint'(ang_cnt) + yaw;
                if ($urandom_range(0, 3) == 0) v = kx * KEY_CNT + ky;
            end
        endcase
        return v[47:0];
    endfunction

    task automatic queue_random(int count);
        row_t r;
        logic [OP_W-1:0] op;
        repeat (count) begin
            op = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            r.word = make_word(op, $urandom_range(0, 1), rand_coord(), rand_coord(),
                               rand_coord(), rand_vertex());
            r.known = 1'b0;
            r.result = '0;
            word_q.push_back(r);
        end
    endtask

    task automatic queue_directed();
        row_t tbl[$];
        row_t r;
        out_t z;
        z = '0;
        r.known = 1'b1;
        r.result = z;
        r.result.out_x = 32768; r.result.out_y = 32768;
        r.word = make_word(OP_VERTEX_TO_COORD, 0, 0, 0, 0, 48'h0000_8000_8000); tbl.push_back(r);
        r.result = z;
        r.result.out_x = -2147450880; r.result.out_y = -2147450880;
        r.result.out_z = -2147450880;
        r.word = make_word(OP_VERTEX_TO_COORD, 1, 0, 0, 0, 48'h0); tbl.push_back(r);
        r.result = z;
        r.result.out_x = 2147450880; r.result.out_y = 2147450880; r.result.out_z = 2147450880;
        r.word = make_word(OP_VERTEX_TO_COORD, 1, 0, 0, 0, 48'hFFFF_FFFF_FFFF); tbl.push_back(r);
        r.result = z;
        r.result.error_code = ERR_POS_RES;
        r.word = make_word(OP_STATE_TO_VERTEX, 0, 5, 6, 7, 0); tbl.push_back(r);
        r.word = make_word(OP_STATE_TO_VERTEX, 1, 5, 6, 7, 0); tbl.push_back(r);
        r.word = make_word(OP_VERTEX_TO_STATE, 1, 0, 0, 0, 48'h1234); tbl.push_back(r);
        r.word = make_word(OP_STATE_TO_ENV, 0, 0, 0, 0, 48'h8000_8000); tbl.push_back(r);
        r.result = z;
        r.word = make_word(3'd5, 1, -1, -1, -1, 48'hFFFF_FFFF_FFFF); tbl.push_back(r);
        r.word = make_word(3'd7, 0, 1, 1, 1, 48'h1); tbl.push_back(r);
        r.known = 1'b0;
        r.word = make_word(OP_COORD_TO_VERTEX, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        tbl.push_back(r);
        r.word = make_word(OP_COORD_TO_VERTEX, 1, 0, -1, 32'h7FFF_FFFF, 0); tbl.push_back(r);
        r.word = make_word(OP_COORD_TO_VERTEX, 1, -1, 0, 32'h8000_0000, 0); tbl.push_back(r);
        r.word = make_word(OP_VERTEX_TO_COORD, 0, 0, 0, 0, 48'hFFFF_0000_FFFF); tbl.push_back(r);
        foreach (tbl[i]) word_q.push_back(tbl[i]);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_PLANE_RES:  plane_res = value;
            REG_HEIGHT_RES: height_res = value;
            REG_POS_RES:    pos_res = value;
            REG_ANG_RES:    ang_res = value;
            REG_ANG_COUNT:  ang_cnt = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] pl, logic [31:0] ht, logic [31:0] ps,
                             logic [31:0] an, logic [31:0] cn);
        cfg_write(REG_PLANE_RES, pl);
        cfg_write(REG_HEIGHT_RES, ht);
        cfg_write(REG_POS_RES, ps);
        cfg_write(REG_ANG_RES, an);
        cfg_write(REG_ANG_COUNT, cn);
    endtask

    task automatic drain();
        while (word_q.size() != 0 || s_valid || conv_expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // sender: bursts with random gaps
    always @(posedge aclk) begin
        row_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (word_q.size() != 0) begin
                r = word_q.pop_front();
                s_valid <= 1'b1;
                s_word <= r.word;
                cur_known <= r.known;
                cur_result <= r.result;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern rotates through four modes
    always @(posedge aclk) begin
        ready_cycle++;
        case ((ready_cycle >> 9) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= (ready_cycle % 8) < 5;
            default: m_ready <= $urandom_range(0, 7) != 0;
        endcase
    end

    // handshakes sampled mid-cycle, ahead of the edge that takes them
    always @(negedge aclk) begin
        out_t want;
        in_fire = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (in_fire)
                conv_expected_q.push_back(cur_known ? cur_result : predict_conversion(s_word));
            if (m_valid && m_ready) begin
                if (conv_expected_q.size() == 0) begin
                    report_mismatch("unexpected word", m_word.vertex_out, 0);
                end else begin
                    want = conv_expected_q.pop_front();
                    if (m_word.vertex_out !== want.vertex_out)
                        report_mismatch("vertex_out", m_word.vertex_out, want.vertex_out);
                    if (m_word.out_x !== want.out_x)
                        report_mismatch("out_x", m_word.out_x, want.out_x);
                    if (m_word.out_y !== want.out_y)
                        report_mismatch("out_y", m_word.out_y, want.out_y);
                    if (m_word.out_z !== want.out_z)
                        report_mismatch("out_z", m_word.out_z, want.out_z);
                    if (m_word.error_code !== want.error_code)
                        report_mismatch("error_code", m_word.error_code, want.error_code);
                end
            end
            if (in_fire || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout");
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_word = '0; m_ready = 1'b0;
        cur_known = 1'b0; cur_result = '0; in_fire = 1'b0;
        error_count = 0; idle_cycles = 0; burst_left = 0; gap_left = 0; ready_cycle = 0;
        plane_res = PLANE_RES_RST; height_res = HEIGHT_RES_RST;
        pos_res = POS_RES_RST; ang_res = ANG_RES_RST; ang_cnt = ANG_CNT_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        queue_directed();
        queue_random(280);
        drain();

        configure(32'd65536, 32'd65536, 32'd65536, 32'd51472, 32'd9);
        queue_random(160);
        drain();
        queue_random(160);
        drain();

        configure(32'd1, 32'd1, 32'd1, 32'd1, 32'd65535);
        queue_random(300);
        drain();

        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        queue_random(300);
        drain();

        configure(32'd0, 32'd0, 32'd32768, 32'd25736, 32'd0);
        queue_random(300);
        drain();

        configure($urandom_range(1, 200000), $urandom_range(1, 200000),
                  $urandom_range(1, 200000), $urandom_range(1, 100000),
                  $urandom_range(1, 400));
        queue_random(300);
        drain();

        if (error_count == 0 && conv_expected_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
